/* sv/newreno_congestion_pacer_macros.svh */
// ----------------------------------------------------------------------------
// newreno_congestion_pacer_macros
// Assertion helpers for the checker file.
// ----------------------------------------------------------------------------
`ifndef NEWRENO_CONGESTION_PACER_MACROS_SVH
`define NEWRENO_CONGESTION_PACER_MACROS_SVH

// same-cycle implication
`define NCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define NCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/ncp_pkg.sv */
// ----------------------------------------------------------------------------
// ncp_pkg
// Types, constants and helpers for the congestion pacer.
// ----------------------------------------------------------------------------
package ncp_pkg;

    localparam logic [15:0] DEFAULT_MTU   = 16'd1280;
    localparam int          INIT_WIN_MTUS = 10;
    localparam int          BURST_MTUS    = 64;
    localparam logic [31:0] MIN_PACE_RTT  = 32'd1000;
    localparam logic [31:0] ALL32         = 32'hFFFF_FFFF;
    localparam int          DIV_STEPS     = 64;
    localparam int          DIV_CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        REQ_RESTART = 3'd0,
        REQ_SENT    = 3'd1,
        REQ_ACK     = 3'd2,
        REQ_LOSS    = 3'd3,
        REQ_DISCARD = 3'd4,
        REQ_CANSEND = 3'd5,
        REQ_PACE    = 3'd6
    } t_req;

    typedef struct packed {
        logic        start;
        logic [31:0] divisor;
        logic [63:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } t_div_rsp;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ALL32 : s[31:0];
    endfunction

    function automatic logic [31:0] floor_sub32(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? (a - b) : 32'd0;
    endfunction

endpackage

/* sv/ncp_divider.sv */
// ----------------------------------------------------------------------------
// ncp_divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module ncp_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ncp_pkg::t_div_req i_req,
    output ncp_pkg::t_div_rsp o_rsp
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [ncp_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [63:0]                  r_dvd, n_dvd;
    logic [31:0]                  r_rem, n_rem;
    logic [31:0]                  r_dsr, n_dsr;
    logic [32:0]                  w_sh;
    logic                         w_ge;

    assign w_sh = {r_rem, r_dvd[63]};
    assign w_ge = w_sh >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = ncp_pkg::DIV_CNT_W'(ncp_pkg::DIV_STEPS - 1);
            n_dvd  = i_req.dividend;
            n_rem  = 32'd0;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? 32'(w_sh - {1'b0, r_dsr}) : w_sh[31:0];
            n_dvd = {r_dvd[62:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_dvd;
    assign o_rsp.remainder = r_rem;

endmodule

/* sv/newreno_congestion_pacer.sv */
// ----------------------------------------------------------------------------
// newreno_congestion_pacer
// NewReno window control with time-based pacing for one connection.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  event   | i_in_valid / o_in_stall + fields | in
//  result  | o_out_valid / i_out_stall + snap | out
//  config  | i_cfg_we / i_cfg_data (mtu)      | in
//
//  Simple events (restart, sent, discard, can-send, loss, slow-start ack)
//  pass through accept, decode and result.  An avoidance ack adds one multiply
//  and one divide.  A pacing query runs up to three passes through the shared
//  bit-serial divider plus multiplies.  Reset is synchronous, active low, and
//  clears the controller state at once.  A result beat that is stalled holds the
//  sequencer in its final state; the event side stalls until it is gone.
// ----------------------------------------------------------------------------
module newreno_congestion_pacer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_byte_count,
    input  logic [31:0] i_rtt_sample_us,
    input  logic [47:0] i_now_us,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_send_allowed,
    output logic [31:0] o_pacing_delay_us,
    output logic [31:0] o_window_bytes,
    output logic [31:0] o_threshold_bytes,
    output logic [31:0] o_in_flight_bytes,
    output logic [31:0] o_smoothed_rtt_us,
    output logic [31:0] o_rtt_variation_us,
    output logic [31:0] o_min_rtt_us
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_DECODE   = 13'b0000000000010,
        S_ACK_MUL  = 13'b0000000000100,
        S_ACK_DIV  = 13'b0000000001000,
        S_P_DIV1   = 13'b0000000010000,
        S_P_MUL1   = 13'b0000000100000,
        S_P_MUL2   = 13'b0000001000000,
        S_P_DIV2   = 13'b0000010000000,
        S_P_CREDIT = 13'b0000100000000,
        S_P_CHECK  = 13'b0001000000000,
        S_P_MUL3   = 13'b0010000000000,
        S_P_DIV3   = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // captured event
    ncp_pkg::t_req r_type;
    logic [31:0]   r_bytes, r_rtt;
    logic [47:0]   r_now;

    // controller state
    logic [15:0] r_mtu;
    logic        r_active, n_active;
    logic [31:0] r_win, n_win;
    logic [31:0] r_ssl, n_ssl;
    logic [31:0] r_infl, n_infl;
    logic [31:0] r_srtt, n_srtt;
    logic [31:0] r_rvar, n_rvar;
    logic [31:0] r_rmin, n_rmin;
    logic [47:0] r_rec, n_rec;
    logic [47:0] r_ptime, n_ptime;
    logic [31:0] r_credit, n_credit;

    // working registers
    logic [31:0] r_prate, n_prate;   // pacing RTT, at least MIN_PACE_RTT
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_qlo, n_qlo;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_prod, n_prod;
    logic [31:0] r_added, n_added;
    logic        r_allowed, n_allowed;
    logic [31:0] r_delay, n_delay;
    logic        r_div_go, n_div_go;

    // result register
    logic        r_ov, n_ov;
    logic        r_o_allowed;
    logic [31:0] r_o_delay, r_o_win, r_o_ssl, r_o_infl, r_o_srtt, r_o_rvar, r_o_rmin;

    logic [15:0] w_mtu;
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_mul;
    logic [31:0] w_diff;
    logic [47:0] w_el;
    logic [31:0] w_half, w_floor2;
    logic [32:0] w_cs;
    logic [31:0] w_csat, w_cap;
    logic [64:0] w_sum;
    logic        w_take;

    ncp_pkg::t_div_req w_dreq;
    ncp_pkg::t_div_rsp w_drsp;

    // zero MTU reads as the default
    assign w_mtu    = (r_mtu == 16'd0) ? ncp_pkg::DEFAULT_MTU : r_mtu;
    assign w_floor2 = {15'd0, w_mtu, 1'b0};
    assign w_cap    = 32'(w_mtu) * 32'(ncp_pkg::BURST_MTUS);
    assign w_take   = !r_ov || !i_out_stall;

    // the one multiplier, operands picked by step
    always_comb begin
        case (r_state)
            S_ACK_MUL: begin
                w_mul_a = 32'(w_mtu);
                w_mul_b = r_bytes;
            end
            S_P_MUL1: begin
                w_mul_a = r_qlo;
                w_mul_b = r_win;
            end
            S_P_MUL2: begin
                w_mul_a = r_rem;
                w_mul_b = r_win;
            end
            S_P_MUL3: begin
                w_mul_a = r_bytes - r_credit;
                w_mul_b = r_prate;
            end
            default: begin
                w_mul_a = 32'd0;
                w_mul_b = 32'd0;
            end
        endcase
    end
    assign w_mul = 64'(w_mul_a) * 64'(w_mul_b);

    // divider: dividend always from r_prod
    assign w_dreq.start    = r_div_go;
    assign w_dreq.dividend = r_prod;
    assign w_dreq.divisor  = (r_state == S_ACK_DIV || r_state == S_P_DIV3) ? r_win : r_prate;

    ncp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    assign w_diff = (r_srtt > r_rtt) ? (r_srtt - r_rtt) : (r_rtt - r_srtt);
    assign w_el   = (r_type == ncp_pkg::REQ_LOSS) ? (r_now - r_rec) : (r_now - r_ptime);
    assign w_half = {1'b0, r_win[31:1]};
    assign w_cs   = {1'b0, r_credit} + {1'b0, r_added};
    assign w_csat = w_cs[32] ? ncp_pkg::ALL32 : w_cs[31:0];
    assign w_sum  = {1'b0, r_acc} + 65'(w_drsp.quotient);

    always_comb begin
        n_state   = r_state;
        n_active  = r_active;
        n_win     = r_win;
        n_ssl     = r_ssl;
        n_infl    = r_infl;
        n_srtt    = r_srtt;
        n_rvar    = r_rvar;
        n_rmin    = r_rmin;
        n_rec     = r_rec;
        n_ptime   = r_ptime;
        n_credit  = r_credit;
        n_prate   = r_prate;
        n_rem     = r_rem;
        n_qlo     = r_qlo;
        n_acc     = r_acc;
        n_prod    = r_prod;
        n_added   = r_added;
        n_allowed = r_allowed;
        n_delay   = r_delay;
        n_div_go  = 1'b0;
        n_ov      = (r_ov && !i_out_stall) ? 1'b0 : r_ov;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_allowed = 1'b0;
                    n_delay   = 32'd0;
                    n_state   = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_DONE;
                if (r_type == ncp_pkg::REQ_RESTART) begin
                    n_active = 1'b1;
                    n_win    = 32'(w_mtu) * 32'(ncp_pkg::INIT_WIN_MTUS);
                    n_ssl    = ncp_pkg::ALL32;
                    n_infl   = 32'd0;
                    n_rec    = 48'd0;
                    n_ptime  = r_now;
                    n_credit = 32'(w_mtu) * 32'(ncp_pkg::INIT_WIN_MTUS);
                end else if (r_active) begin
                    case (r_type)
                        ncp_pkg::REQ_SENT: begin
                            n_infl   = ncp_pkg::sat_add32(r_infl, r_bytes);
                            n_credit = ncp_pkg::floor_sub32(r_credit, r_bytes);
                        end
                        ncp_pkg::REQ_ACK: begin
                            n_infl = ncp_pkg::floor_sub32(r_infl, r_bytes);
                            if (r_srtt == 32'd0) begin
                                n_srtt = r_rtt;
                                n_rvar = {1'b0, r_rtt[31:1]};
                                n_rmin = r_rtt;
                            end else begin
                                if (r_rtt < r_rmin) begin
                                    n_rmin = r_rtt;
                                end
                                n_rvar = 32'((34'(r_rvar) * 34'd3 + 34'(w_diff)) >> 2);
                                n_srtt = 32'((35'(r_srtt) * 35'd7 + 35'(r_rtt)) >> 3);
                            end
                            if (r_win < r_ssl) begin
                                n_win = ncp_pkg::sat_add32(r_win, r_bytes);
                            end else if (r_win != 32'd0) begin
                                n_state = S_ACK_MUL;
                            end
                        end
                        ncp_pkg::REQ_LOSS: begin
                            n_infl = ncp_pkg::floor_sub32(r_infl, r_bytes);
                            if (w_el > 48'(r_srtt)) begin
                                n_rec = r_now;
                                n_ssl = (w_half < w_floor2) ? w_floor2 : w_half;
                                n_win = (w_half < w_floor2) ? w_floor2 : w_half;
                            end
                        end
                        ncp_pkg::REQ_DISCARD: begin
                            n_infl = ncp_pkg::floor_sub32(r_infl, r_bytes);
                        end
                        ncp_pkg::REQ_CANSEND: begin
                            n_allowed = (33'(r_infl) + 33'(r_bytes)) <= 33'(r_win);
                        end
                        ncp_pkg::REQ_PACE: begin
                            n_prate  = (r_srtt < ncp_pkg::MIN_PACE_RTT) ?
                                       ncp_pkg::MIN_PACE_RTT : r_srtt;
                            n_prod   = 64'(w_el);
                            n_div_go = 1'b1;
                            n_state  = S_P_DIV1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_ACK_MUL: begin
                n_prod   = w_mul;
                n_div_go = 1'b1;
                n_state  = S_ACK_DIV;
            end

            S_ACK_DIV: begin
                if (w_drsp.done) begin
                    n_win   = (w_drsp.quotient[63:32] != 32'd0) ? ncp_pkg::ALL32 :
                              ncp_pkg::sat_add32(r_win, w_drsp.quotient[31:0]);
                    n_state = S_DONE;
                end
            end

            // elapsed / rtt
            S_P_DIV1: begin
                if (w_drsp.done) begin
                    n_rem = w_drsp.remainder;
                    n_qlo = w_drsp.quotient[31:0];
                    if (w_drsp.quotient[63:32] != 32'd0) begin
                        n_added = (r_win != 32'd0) ? ncp_pkg::ALL32 : 32'd0;
                        n_state = S_P_CREDIT;
                    end else begin
                        n_state = S_P_MUL1;
                    end
                end
            end

            S_P_MUL1: begin
                n_acc   = w_mul;
                n_state = S_P_MUL2;
            end

            S_P_MUL2: begin
                n_prod   = w_mul;
                n_div_go = 1'b1;
                n_state  = S_P_DIV2;
            end

            // remainder * window / rtt, added to q * window
            S_P_DIV2: begin
                if (w_drsp.done) begin
                    n_added = (w_sum[64:32] != 33'd0) ? ncp_pkg::ALL32 : w_sum[31:0];
                    n_state = S_P_CREDIT;
                end
            end

            S_P_CREDIT: begin
                n_credit = (w_csat > w_cap) ? w_cap : w_csat;
                n_state  = S_P_CHECK;
            end

            S_P_CHECK: begin
                if (r_credit >= r_bytes) begin
                    n_ptime = r_now;
                    n_delay = 32'd0;
                    n_state = S_DONE;
                end else if (r_win == 32'd0) begin
                    n_delay = ncp_pkg::ALL32;
                    n_state = S_DONE;
                end else begin
                    n_state = S_P_MUL3;
                end
            end

            S_P_MUL3: begin
                n_prod   = w_mul;
                n_div_go = 1'b1;
                n_state  = S_P_DIV3;
            end

            // missing credit * rtt / window, at least 1 us
            S_P_DIV3: begin
                if (w_drsp.done) begin
                    if (w_drsp.quotient[63:32] != 32'd0) begin
                        n_delay = ncp_pkg::ALL32;
                    end else if (w_drsp.quotient[31:0] == 32'd0) begin
                        n_delay = 32'd1;
                    end else begin
                        n_delay = w_drsp.quotient[31:0];
                    end
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (w_take) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mtu    <= ncp_pkg::DEFAULT_MTU;
            r_active <= 1'b0;
            r_win    <= 32'd0;
            r_ssl    <= ncp_pkg::ALL32;
            r_infl   <= 32'd0;
            r_srtt   <= 32'd0;
            r_rvar   <= 32'd0;
            r_rmin   <= 32'd0;
            r_rec    <= 48'd0;
            r_ptime  <= 48'd0;
            r_credit <= 32'd0;
            r_div_go <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_mtu <= i_cfg_data;
            end
            r_active <= n_active;
            r_win    <= n_win;
            r_ssl    <= n_ssl;
            r_infl   <= n_infl;
            r_srtt   <= n_srtt;
            r_rvar   <= n_rvar;
            r_rmin   <= n_rmin;
            r_rec    <= n_rec;
            r_ptime  <= n_ptime;
            r_credit <= n_credit;
            r_div_go <= n_div_go;
            r_ov     <= n_ov;
        end

        if (r_state == S_IDLE && i_in_valid) begin
            r_type  <= ncp_pkg::t_req'(i_req_type);
            r_bytes <= i_byte_count;
            r_rtt   <= i_rtt_sample_us;
            r_now   <= i_now_us;
        end
        r_prate   <= n_prate;
        r_rem     <= n_rem;
        r_qlo     <= n_qlo;
        r_acc     <= n_acc;
        r_prod    <= n_prod;
        r_added   <= n_added;
        r_allowed <= n_allowed;
        r_delay   <= n_delay;

        if (r_state == S_DONE && w_take) begin
            r_o_allowed <= r_allowed;
            r_o_delay   <= r_delay;
            r_o_win     <= r_win;
            r_o_ssl     <= r_ssl;
            r_o_infl    <= r_infl;
            r_o_srtt    <= r_srtt;
            r_o_rvar    <= r_rvar;
            r_o_rmin    <= r_rmin;
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_ov;
    assign o_send_allowed     = r_o_allowed;
    assign o_pacing_delay_us  = r_o_delay;
    assign o_window_bytes     = r_o_win;
    assign o_threshold_bytes  = r_o_ssl;
    assign o_in_flight_bytes  = r_o_infl;
    assign o_smoothed_rtt_us  = r_o_srtt;
    assign o_rtt_variation_us = r_o_rvar;
    assign o_min_rtt_us       = r_o_rmin;

endmodule

/* sv/ncp_checker.sv */
// ----------------------------------------------------------------------------
// ncp_checker
// Port-level checks on the congestion pacer, bound to the top level.
// ----------------------------------------------------------------------------
`include "newreno_congestion_pacer_macros.svh"

module ncp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_send_allowed,
    input logic [31:0] o_pacing_delay_us,
    input logic [31:0] o_window_bytes,
    input logic [31:0] o_threshold_bytes
);

    // stalled result beat holds
    `NCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_window_bytes))

    // one event in work at a time
    `NCP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // only one query answer can be nonzero
    `NCP_ASSERT_NOW(a_one_answer, i_clk, i_rst_n, o_out_valid, !(o_send_allowed && (o_pacing_delay_us != 32'd0)))

    // after a reduction the window never falls below the threshold
    `NCP_ASSERT_NOW(a_win_ge_thr, i_clk, i_rst_n, o_out_valid && (o_threshold_bytes != 32'hFFFF_FFFF), o_window_bytes >= o_threshold_bytes)

endmodule

bind newreno_congestion_pacer ncp_checker u_ncp_checker (.*);
